@@ design/acpu_pkg.sv @@
// Shared types and constants for the accumulator machine execute block.
// No dependencies; used by acpu_alu, accumulator_cpu_execute_top and tb_top.
package acpu_pkg;

   localparam int WORD_W    = 16;
   localparam int ADDR_W    = 12;
   localparam int MEM_DEPTH = 4096;
   localparam int OPC_W     = 4;
   localparam int OPND_W    = 16;

   typedef enum logic [OPC_W-1:0] {
      OP_LDA  = 4'd0,
      OP_ADD  = 4'd1,
      OP_SUB  = 4'd2,
      OP_LDI  = 4'd3,
      OP_JMP  = 4'd4,
      OP_JMI  = 4'd5,
      OP_JEQ  = 4'd6,
      OP_STA  = 4'd7,
      OP_LSR  = 4'd8,
      OP_STP  = 4'd9,
      OP_ORG  = 4'd10,
      OP_DCW  = 4'd11,
      OP_NONE = 4'd12
   } op_type;

   typedef struct packed {
      logic [WORD_W-1:0] acc;
      logic [ADDR_W-1:0] pc;
      logic [ADDR_W-1:0] ptr;
   } arch_state_type;

   typedef struct packed {
      arch_state_type    state;
      logic              halt;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
   } exec_result_type;

endpackage

@@ design/acpu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered, read-first output.
// No dependencies.
module acpu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/acpu_alu.sv @@
// Instruction execute logic: next accumulator, PC, setup pointer, halt flag and memory write.
// Depends on acpu_pkg.
module acpu_alu (
   input  logic [acpu_pkg::OPC_W-1:0]  op_code,
   input  logic [acpu_pkg::OPND_W-1:0] op_value,
   input  logic [acpu_pkg::WORD_W-1:0] mem_data,
   input  acpu_pkg::arch_state_type    cur,
   output acpu_pkg::exec_result_type   res
);
   import acpu_pkg::*;

   logic [ADDR_W-1:0] addr;
   logic [ADDR_W-1:0] pc_inc;
   logic [WORD_W-1:0] opnd_word;
   logic [WORD_W-1:0] half_sum;
   logic [WORD_W-1:0] acc_half;
   logic              acc_neg;
   logic              acc_zero;

   assign addr      = op_value[ADDR_W-1:0];
   assign pc_inc    = cur.pc + ADDR_W'(1);
   assign opnd_word = WORD_W'(signed'(op_value));
   assign acc_neg   = cur.acc[WORD_W-1];
   assign acc_zero  = (cur.acc == '0);
   // round toward zero: bias negatives by one before the arithmetic shift
   assign half_sum  = cur.acc + WORD_W'(acc_neg);
   assign acc_half  = WORD_W'($signed(half_sum) >>> 1);

   always_comb begin
      res.state   = cur;
      res.state.pc = pc_inc;
      res.halt    = 1'b0;
      res.wr_en   = 1'b0;
      res.wr_addr = addr;
      res.wr_data = cur.acc;
      case (op_code)
         OP_LDA: res.state.acc = mem_data;
         OP_ADD: res.state.acc = cur.acc + mem_data;
         OP_SUB: res.state.acc = cur.acc - mem_data;
         OP_LDI: res.state.acc = opnd_word;
         OP_JMP: res.state.pc = addr;
         OP_JMI: begin
            if (acc_neg) begin
               res.state.pc = addr;
            end
         end
         OP_JEQ: begin
            if (acc_zero) begin
               res.state.pc = addr;
            end
         end
         OP_STA: res.wr_en = 1'b1;
         OP_LSR: res.state.acc = acc_half;
         OP_STP: begin
            res.state.pc = cur.pc;
            res.halt     = 1'b1;
         end
         OP_ORG: begin
            res.state.pc  = cur.pc;
            res.state.ptr = addr;
         end
         OP_DCW: begin
            res.state.pc  = cur.pc;
            res.state.ptr = cur.ptr + ADDR_W'(1);
            res.wr_en     = 1'b1;
            res.wr_addr   = cur.ptr;
            res.wr_data   = opnd_word;
         end
         default: ;
      endcase
   end

endmodule

@@ design/accumulator_cpu_execute_top.sv @@
// Accumulator machine execute block: top level with data memory and result register.
// Depends on acpu_pkg, acpu_ram and acpu_alu.
// Result word: the memory read is registered at the accepting edge, then the execute stage writes the result register.
// Throughput: one word per cycle; the single execute stage holds while the result is stalled.
// Reset: synchronous; afterwards a clearing pass zeroes the 4096-word data memory,
// one word a cycle, with req_stall high until the last word is written.
module accumulator_cpu_execute_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [acpu_pkg::OPC_W-1:0]   req_op_code,
   input  logic [acpu_pkg::OPND_W-1:0]  req_op_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [acpu_pkg::ADDR_W-1:0]  rsp_next_pc,
   output logic [acpu_pkg::WORD_W-1:0]  rsp_acc_value,
   output logic                         rsp_halted
);
   import acpu_pkg::*;

   logic                  clearing_ff, clearing_in;
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;

   logic                  ex_valid_ff, ex_valid_in;
   logic [OPC_W-1:0]      ex_code_ff;
   logic [OPND_W-1:0]     ex_value_ff;

   logic                  fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]     fwd_addr_ff;
   logic [WORD_W-1:0]     fwd_data_ff;

   arch_state_type        state_ff, state_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_pc_ff;
   logic [WORD_W-1:0]     rsp_acc_ff;
   logic                  rsp_halt_ff;

   logic                  accept;
   logic                  ex_fire;
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [WORD_W-1:0]     ram_wr_data;
   logic [WORD_W-1:0]     ram_rd_data;
   logic [WORD_W-1:0]     mem_data;
   exec_result_type       ex_res;

   assign ex_fire   = ex_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing_ff || (ex_valid_ff && !ex_fire);
   assign accept    = req_valid && !req_stall;

   // clearing pass
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   assign ram_wr_en   = clearing_ff || (ex_fire && ex_res.wr_en);
   assign ram_wr_addr = clearing_ff ? clr_addr_ff : ex_res.wr_addr;
   assign ram_wr_data = clearing_ff ? '0 : ex_res.wr_data;

   acpu_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_DEPTH)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_op_value[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // bypass a write that landed on the same edge as this word's read
   assign mem_data = (fwd_valid_ff && (fwd_addr_ff == ex_value_ff[ADDR_W-1:0]))
                     ? fwd_data_ff : ram_rd_data;

   acpu_alu u_alu (
      .op_code  (ex_code_ff),
      .op_value (ex_value_ff),
      .mem_data (mem_data),
      .cur      (state_ff),
      .res      (ex_res)
   );

   always_comb begin
      ex_valid_in  = accept || (ex_valid_ff && !ex_fire);
      fwd_valid_in = accept ? (ex_fire && ex_res.wr_en) : fwd_valid_ff;
      state_in     = ex_fire ? ex_res.state : state_ff;
      rsp_valid_in = ex_fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         ex_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         ex_valid_ff  <= ex_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_code_ff  <= req_op_code;
         ex_value_ff <= req_op_value;
         fwd_addr_ff <= ex_res.wr_addr;
         fwd_data_ff <= ex_res.wr_data;
      end
      if (ex_fire) begin
         rsp_pc_ff   <= ex_res.state.pc;
         rsp_acc_ff  <= ex_res.state.acc;
         rsp_halt_ff <= ex_res.halt;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_pc   = rsp_pc_ff;
   assign rsp_acc_value = rsp_acc_ff;
   assign rsp_halted    = rsp_halt_ff;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for accumulator_cpu_execute_top: instruction words in, result words out.
// Holds its own model of accumulator, PC, data memory and setup pointer; depends on acpu_pkg.
module tb_top;
   import acpu_pkg::*;

   localparam logic [OPC_W-1:0] OP_LAST_CODE = 4'hF;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [ADDR_W-1:0] pc;
      logic [WORD_W-1:0] acc;
      logic              halt;
   } outcome_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OPC_W-1:0]    req_op_code;
   logic [OPND_W-1:0]   req_op_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [ADDR_W-1:0]   rsp_next_pc;
   logic [WORD_W-1:0]   rsp_acc_value;
   logic                rsp_halted;

   logic [WORD_W-1:0]   acc_model;
   logic [ADDR_W-1:0]   pc_model;
   logic [ADDR_W-1:0]   ptr_model;
   logic [WORD_W-1:0]   mem_model [0:MEM_DEPTH-1];

   outcome_type         pending_outcomes [$];
   logic                idle_on;
   logic                hold_request;
   int                  words_sent;
   int                  words_checked;
   int                  mismatches;
   int                  halts_seen;
   int                  branches_taken;
   int                  cycle_count;

   accumulator_cpu_execute_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op_code   (req_op_code),
      .req_op_value  (req_op_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_next_pc   (rsp_next_pc),
      .rsp_acc_value (rsp_acc_value),
      .rsp_halted    (rsp_halted)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_outcomes.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic void execute_word(input logic [OPC_W-1:0] code,
                                        input logic [OPND_W-1:0] opnd);
      logic [ADDR_W-1:0]        addr;
      logic [ADDR_W-1:0]        npc;
      logic                     halt_flag;
      logic signed [WORD_W-1:0] sacc;
      outcome_type              o;
      addr      = opnd[ADDR_W-1:0];
      npc       = pc_model + 1'b1;
      halt_flag = 1'b0;
      sacc      = acc_model;
      case (code)
         OP_LDA: acc_model = mem_model[addr];
         OP_ADD: acc_model = acc_model + mem_model[addr];
         OP_SUB: acc_model = acc_model - mem_model[addr];
         OP_LDI: acc_model = opnd;
         OP_JMP: begin
            npc = addr;
            branches_taken++;
         end
         OP_JMI: if (sacc < 0) begin
            npc = addr;
            branches_taken++;
         end
         OP_JEQ: if (sacc == 0) begin
            npc = addr;
            branches_taken++;
         end
         OP_STA: mem_model[addr] = acc_model;
         OP_LSR: acc_model = WORD_W'(sacc / 16'sd2);
         OP_STP: begin
            halt_flag = 1'b1;
            npc = pc_model;
            halts_seen++;
         end
         OP_ORG: begin
            ptr_model = addr;
            npc = pc_model;
         end
         OP_DCW: begin
            mem_model[ptr_model] = opnd;
            ptr_model = ptr_model + 1'b1;
            npc = pc_model;
         end
         default: ;
      endcase
      pc_model = npc;
      o.pc   = pc_model;
      o.acc  = acc_model;
      o.halt = halt_flag;
      pending_outcomes.push_back(o);
   endfunction

   // issue one word at the falling edge, hold until accepted, return at the next falling edge
   task automatic send_word(input logic [OPC_W-1:0] code, input logic [OPND_W-1:0] opnd);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_op_code  <= code;
      req_op_value <= opnd;
      do @(posedge clock); while (req_stall !== 1'b0);
      execute_word(code, opnd);
      words_sent++;
      @(negedge clock);
   endtask

   function automatic logic [OPC_W-1:0] pick_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 82)
         return OPC_W'($urandom_range(OP_LDA, OP_LSR));
      else if (r < 86)
         return OP_STP;
      else if (r < 90)
         return OP_ORG;
      else if (r < 95)
         return OP_DCW;
      else
         return OPC_W'($urandom_range(OP_NONE, OP_LAST_CODE));
   endfunction

   // bias addresses toward a small window at each end of memory so reads hit written data
   function automatic logic [OPND_W-1:0] pick_operand();
      logic [OPND_W-1:0] v;
      int                r;
      v = OPND_W'($urandom);
      r = $urandom_range(0, 9);
      if (r < 5)
         v[ADDR_W-1:0] = ADDR_W'($urandom_range(0, 31));
      else if (r < 7)
         v[ADDR_W-1:0] = ADDR_W'(MEM_DEPTH - 1 - $urandom_range(0, 7));
      else if (r == 7)
         v = '0;
      return v;
   endfunction

   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         words_checked++;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR %0t: result word with none expected: pc=%0d acc=%h halt=%b",
                        $realtime, rsp_next_pc, rsp_acc_value, rsp_halted);
         end else begin
            e = pending_outcomes.pop_front();
            if (rsp_next_pc !== e.pc || rsp_acc_value !== e.acc || rsp_halted !== e.halt) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR %0t: pc exp %0d got %0d, acc exp %h got %h, halt exp %b got %b",
                           $realtime, e.pc, rsp_next_pc, e.acc, rsp_acc_value,
                           e.halt, rsp_halted);
            end
         end
      end
   end

   initial begin : rsp_side
      int hold_count;
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
               @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic test_directed();
      int k;
      send_word(OP_LDI, 16'h7FFF);
      send_word(OP_STA, 16'h0010);
      send_word(OP_LDI, 16'h8000);
      send_word(OP_LSR, 16'h0000);
      send_word(OP_JMI, 16'h0FFF);
      send_word(OP_NONE, 16'h0000);
      send_word(OP_ORG, 16'hFFFF);
      send_word(OP_DCW, 16'h7FFF);
      send_word(OP_DCW, 16'h8000);
      send_word(OP_LDA, 16'hFFFF);
      send_word(OP_ADD, 16'h0000);
      send_word(OP_LSR, 16'h0000);
      send_word(OP_JEQ, 16'h0ABC);
      send_word(OP_ADD, 16'h0010);
      send_word(OP_ADD, 16'h0FFF);
      send_word(OP_SUB, 16'h1000);
      send_word(OP_JMI, 16'h0123);
      send_word(OP_JEQ, 16'h0456);
      send_word(OP_LSR, 16'h0000);
      send_word(OP_JMP, 16'hFFFF);
      send_word(OP_STP, 16'hFFFF);
      send_word(OP_STP, 16'h0000);
      send_word(OP_NONE, 16'hFFFF);
      for (k = 1; k <= OP_LAST_CODE - OP_NONE; k++)
         send_word(OP_NONE + OPC_W'(k), 16'h5A5A);
   endtask

   // preload data with ORG and DCW, then run a short stretch of instructions over it
   task automatic test_program_sequences(input int count);
      int n;
      int burst;
      n = 0;
      while (n < count) begin
         send_word(OP_ORG, pick_operand());
         n++;
         burst = $urandom_range(2, 8);
         repeat (burst) begin
            send_word(OP_DCW, pick_operand());
            n++;
         end
         burst = $urandom_range(4, 12);
         repeat (burst) begin
            send_word(pick_code(), pick_operand());
            n++;
         end
      end
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      repeat (60) send_word(pick_code(), pick_operand());
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) begin
         if ($urandom_range(0, 2) == 0)
            send_word(OPC_W'($urandom_range(0, OP_LAST_CODE)), OPND_W'($urandom));
         else
            send_word(pick_code(), pick_operand());
      end
   endtask

   task automatic test_quiet_tail(input int count);
      idle_on = 1'b0;
      test_random_mix(count);
   endtask

   initial begin
      int k;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op_code  = OP_NONE;
      req_op_value = '0;
      idle_on      = 1'b1;
      hold_request = 1'b0;
      acc_model    = '0;
      pc_model     = '0;
      ptr_model    = '0;
      for (k = 0; k < MEM_DEPTH; k++)
         mem_model[k] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_program_sequences(700);
      test_backpressure();
      test_random_mix(650);
      test_quiet_tail(250);
      req_valid <= 1'b0;

      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Ran %0d instructions, checked %0d result words, %0d mismatches",
               words_sent, words_checked, mismatches);
      $display("Saw %0d halts and %0d taken branches, with idle bursts and a long output hold",
               halts_seen, branches_taken);
      if (mismatches == 0 && pending_outcomes.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ filelist.f @@
design/acpu_pkg.sv
design/acpu_ram.sv
design/acpu_alu.sv
design/accumulator_cpu_execute_top.sv
tb/tb_top.sv
